@@ rtl/core/tcc_pkg.sv @@
// Shared types, register indexes and constants for the terrain column classifier.
package tcc_pkg;

    localparam int unsigned GroundToleranceMm = 80;

    // Reciprocal of five, scaled by two to the power RecipShift, for the 0.8 threshold.
    localparam int unsigned RecipShift = 21;
    localparam logic [18:0] RecipFive = 19'd419431;

    typedef enum logic [2:0] {
        REG_ROBOT_TALL        = 3'd0,
        REG_SLOPE_SPAN_MAX    = 3'd1,
        REG_STEP_SPAN_MIN     = 3'd2,
        REG_STEP_SPAN_MAX     = 3'd3,
        REG_TALL_OBSTACLE_MIN = 3'd4,
        REG_DENSE_OCCUPANCY   = 3'd5,
        REG_SLOPE_NORMAL_MIN  = 3'd6,
        REG_WALL_NORMAL_MAX   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLASS_FREE = 2'd0,
        CLASS_STEP = 2'd1,
        CLASS_OBST = 2'd2
    } cell_class_t;

    typedef enum logic [1:0] {
        PRIOR_UNKNOWN = 2'd0,
        PRIOR_STEP    = 2'd1,
        PRIOR_FREE    = 2'd2
    } prior_mark_t;

    typedef struct packed {
        logic [11:0] robot_tall;
        logic [10:0] slope_span_max;
        logic [10:0] step_span_min;
        logic [10:0] step_span_max;
        logic [11:0] tall_obstacle_min;
        logic [15:0] dense_occupancy;
        logic [15:0] slope_normal_min;
        logic [15:0] wall_normal_max;
    } cfg_t;

    // Rule outcomes that need no height arithmetic, worked out in the first stage.
    typedef struct packed {
        logic prior_step;
        logic prior_free;
        logic few_points;
        logic slope_normal;
        logic wall_normal;
        logic gentle_normal;
        logic dense_wide;
        logic span_small;
        logic edge_drop;
        logic mid_normal;
    } flags_t;

endpackage

@@ rtl/core/tcc_regs.sv @@
// Configuration register file for the terrain column classifier.
module tcc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output tcc_pkg::cfg_t      cfg
);

    tcc_pkg::cfg_t cfg_reg;
    tcc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tcc_pkg::reg_idx_t'(cfg_index))
                tcc_pkg::REG_ROBOT_TALL:        cfg_next.robot_tall        = cfg_data[11:0];
                tcc_pkg::REG_SLOPE_SPAN_MAX:    cfg_next.slope_span_max    = cfg_data[10:0];
                tcc_pkg::REG_STEP_SPAN_MIN:     cfg_next.step_span_min     = cfg_data[10:0];
                tcc_pkg::REG_STEP_SPAN_MAX:     cfg_next.step_span_max     = cfg_data[10:0];
                tcc_pkg::REG_TALL_OBSTACLE_MIN: cfg_next.tall_obstacle_min = cfg_data[11:0];
                tcc_pkg::REG_DENSE_OCCUPANCY:   cfg_next.dense_occupancy   = cfg_data;
                tcc_pkg::REG_SLOPE_NORMAL_MIN:  cfg_next.slope_normal_min  = cfg_data;
                tcc_pkg::REG_WALL_NORMAL_MAX:   cfg_next.wall_normal_max   = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.robot_tall        <= 12'd500;
            cfg_reg.slope_span_max    <= 11'd80;
            cfg_reg.step_span_min     <= 11'd120;
            cfg_reg.step_span_max     <= 11'd230;
            cfg_reg.tall_obstacle_min <= 12'd250;
            cfg_reg.dense_occupancy   <= 16'd128;
            cfg_reg.slope_normal_min  <= 16'd28377;
            cfg_reg.wall_normal_max   <= 16'd16384;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/tcc_pipe.sv @@
// Three-stage classification pipeline: flags, height levels, rule chain.
module tcc_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  tcc_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] robot_z,
    input  logic [9:0]         leg_offset,
    input  logic signed [15:0] column_low,
    input  logic signed [15:0] column_high,
    input  logic [15:0]        height_span,
    input  logic [15:0]        point_total,
    input  logic [15:0]        occupancy,
    input  logic               normal_ok,
    input  logic [15:0]        normal_up,
    input  logic               cliff_mark,
    input  logic               lower_known,
    input  logic [1:0]         prior_mark,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         cell_class
);

    // Stage valid bits and per-stage readiness.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // Stage 1 payload.
    tcc_pkg::flags_t    f1_reg, f1_next;
    logic signed [16:0] bottom1_reg, bottom1_next;
    logic signed [15:0] low1_reg, high1_reg;
    logic [15:0]        occ1_reg;
    logic [15:0]        thr1_reg, thr1_next;
    logic [36:0]        thr_prod;

    // Stage 2 payload.
    tcc_pkg::flags_t    f2_reg;
    logic               mid_free2_reg, mid_free2_next;
    logic signed [17:0] top2_reg, top2_next;
    logic signed [17:0] ground2_reg, ground2_next;
    logic signed [17:0] slope_lim2_reg, slope_lim2_next;
    logic signed [17:0] step_lim2_reg, step_lim2_next;
    logic signed [15:0] low2_reg, high2_reg;

    // Stage 3 result.
    tcc_pkg::cell_class_t class3_reg, class3_next;

    logic signed [16:0] rz_ext, leg_ext, bottom_ext;
    logic signed [17:0] bottom_wide, low_wide, high_wide;
    logic               blocks, above_top, low_le_slope, low_le_step;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: robot bottom, span and normal tests, occupancy threshold.
    assign rz_ext       = {robot_z[15], robot_z};
    assign leg_ext      = {7'd0, leg_offset};
    assign bottom1_next = rz_ext - leg_ext;

    // floor(dense * 4 / 5) through a scaled reciprocal; exact for every 16-bit value.
    assign thr_prod  = {19'd0, cfg.dense_occupancy, 2'b00} * {18'd0, tcc_pkg::RecipFive};
    assign thr1_next = thr_prod[tcc_pkg::RecipShift +: 16];

    always_comb
    begin
        f1_next.prior_step    = (prior_mark == tcc_pkg::PRIOR_STEP);
        f1_next.prior_free    = (prior_mark == tcc_pkg::PRIOR_FREE);
        f1_next.few_points    = (point_total < 16'd2);
        f1_next.slope_normal  = normal_ok && (normal_up >= cfg.slope_normal_min);
        f1_next.wall_normal   = normal_ok && (normal_up < cfg.wall_normal_max);
        f1_next.gentle_normal = normal_ok && (normal_up >= cfg.wall_normal_max);
        f1_next.dense_wide    = (occupancy > cfg.dense_occupancy)
                                && (height_span > {5'd0, cfg.slope_span_max});
        f1_next.span_small    = (height_span < {5'd0, cfg.slope_span_max});
        f1_next.edge_drop     = cliff_mark && lower_known;
        f1_next.mid_normal    = normal_ok && (normal_up >= cfg.wall_normal_max)
                                && (normal_up < cfg.slope_normal_min);
    end

    // Stage 2: robot top, ground level, the two platform limits and the mid-normal occupancy test.
    assign bottom_ext      = bottom1_reg;
    assign bottom_wide     = {bottom_ext[16], bottom_ext};
    assign top2_next       = bottom_wide + $signed({6'd0, cfg.robot_tall});
    assign ground2_next    = bottom_wide + 18'(tcc_pkg::GroundToleranceMm);
    assign slope_lim2_next = bottom_wide + 18'(tcc_pkg::GroundToleranceMm)
                             + $signed({7'd0, cfg.slope_span_max});
    assign step_lim2_next  = bottom_wide + 18'(tcc_pkg::GroundToleranceMm)
                             + $signed({7'd0, cfg.step_span_max});
    assign mid_free2_next  = f1_reg.mid_normal && (occ1_reg < thr1_reg);

    // Stage 3: height compares and the ordered rule chain.
    assign low_wide     = {{2{low2_reg[15]}}, low2_reg};
    assign high_wide    = {{2{high2_reg[15]}}, high2_reg};
    assign blocks       = (low_wide < top2_reg) && (high_wide > ground2_reg);
    assign above_top    = (low_wide > top2_reg);
    assign low_le_slope = (low_wide <= slope_lim2_reg);
    assign low_le_step  = (low_wide <= step_lim2_reg);

    always_comb
    begin
        if (f2_reg.prior_step)
            class3_next = tcc_pkg::CLASS_STEP;
        else if (f2_reg.prior_free)
            class3_next = tcc_pkg::CLASS_FREE;
        else if (f2_reg.few_points || above_top)
            class3_next = tcc_pkg::CLASS_FREE;
        else if (f2_reg.slope_normal && low_le_slope)
            class3_next = tcc_pkg::CLASS_FREE;
        else if (f2_reg.slope_normal && low_le_step)
            class3_next = tcc_pkg::CLASS_STEP;
        else if (f2_reg.dense_wide && !f2_reg.gentle_normal && blocks)
            class3_next = tcc_pkg::CLASS_OBST;
        else if (f2_reg.wall_normal && blocks)
            class3_next = tcc_pkg::CLASS_OBST;
        else if (f2_reg.span_small)
            class3_next = tcc_pkg::CLASS_FREE;
        else if (f2_reg.edge_drop)
            class3_next = tcc_pkg::CLASS_STEP;
        else if (mid_free2_reg)
            class3_next = tcc_pkg::CLASS_FREE;
        else
            // Step range, tall obstacle and the default all reduce to the passage test.
            class3_next = blocks ? tcc_pkg::CLASS_OBST : tcc_pkg::CLASS_FREE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            f1_reg      <= f1_next;
            bottom1_reg <= bottom1_next;
            low1_reg    <= column_low;
            high1_reg   <= column_high;
            occ1_reg    <= occupancy;
            thr1_reg    <= thr1_next;
        end
        if (rdy2 && v1_reg)
        begin
            f2_reg         <= f1_reg;
            mid_free2_reg  <= mid_free2_next;
            top2_reg       <= top2_next;
            ground2_reg    <= ground2_next;
            slope_lim2_reg <= slope_lim2_next;
            step_lim2_reg  <= step_lim2_next;
            low2_reg       <= low1_reg;
            high2_reg      <= high1_reg;
        end
        if (rdy3 && v2_reg)
            class3_reg <= class3_next;
    end

    assign out_valid  = v3_reg;
    assign cell_class = class3_reg;

endmodule

@@ rtl/core/terrain_column_classifier_top.sv @@
// Top level of the terrain column classifier: register file and classification pipeline.
//
// One input transfer carries a map column's height statistics together with the robot
// height and leg offset; one output transfer returns its class (free, step or obstacle).
// Both channels use valid and ready. Configuration is written through cfg_we, cfg_index
// and cfg_data, one register per cycle with no wait. The user must write only while the block
// is idle; the block itself does not enforce it. An input passes the stage 1, stage 2 and
// stage 3 registers before out_valid rises. The first stage forms the robot bottom and the
// threshold tests, the second the top, ground and platform limits, the third the height
// compares and the rule chain, whose result register drives the output. Throughput is one
// column per cycle while out_ready stays high; every stage carries its own valid bit.
// When the receiver stalls, results stay in their stages and in_ready falls only once
// all three stages hold a column; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (robot height 500 mm,
// slope span 80 mm, step range 120 to 230 mm, tall obstacle 250 mm, dense occupancy
// 0.5, slope normal 0.866, wall normal 0.5).
module terrain_column_classifier_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] robot_z,
    input  logic [9:0]         leg_offset,
    input  logic signed [15:0] column_low,
    input  logic signed [15:0] column_high,
    input  logic [15:0]        height_span,
    input  logic [15:0]        point_total,
    input  logic [15:0]        occupancy,
    input  logic               normal_ok,
    input  logic [15:0]        normal_up,
    input  logic               cliff_mark,
    input  logic               lower_known,
    input  logic [1:0]         prior_mark,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         cell_class
);

    tcc_pkg::cfg_t cfg;

    tcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcc_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .robot_z     (robot_z),
        .leg_offset  (leg_offset),
        .column_low  (column_low),
        .column_high (column_high),
        .height_span (height_span),
        .point_total (point_total),
        .occupancy   (occupancy),
        .normal_ok   (normal_ok),
        .normal_up   (normal_up),
        .cliff_mark  (cliff_mark),
        .lower_known (lower_known),
        .prior_mark  (prior_mark),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_class  (cell_class)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the terrain column classifier: stimulus, scoreboard and checks.
`timescale 1ns / 100ps

module tb_top;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 12;
    localparam int ItemsPerSetting = 110;
    localparam int SettingCount = 8;

    typedef struct {
        logic signed [15:0] robot_z;
        logic [9:0]         leg_offset;
        logic signed [15:0] column_low;
        logic signed [15:0] column_high;
        logic [15:0]        height_span;
        logic [15:0]        point_total;
        logic [15:0]        occupancy;
        logic               normal_ok;
        logic [15:0]        normal_up;
        logic               cliff_mark;
        logic               lower_known;
        logic [1:0]         prior_mark;
    } column_t;

    // Holds the expected classes in transfer order and the thresholds behind them.
    class scoreboard_t;
        logic [11:0] robot_tall;
        logic [10:0] slope_span_max;
        logic [10:0] step_span_min;
        logic [10:0] step_span_max;
        logic [11:0] tall_obstacle_min;
        logic [15:0] dense_occupancy;
        logic [15:0] slope_normal_min;
        logic [15:0] wall_normal_max;
        tcc_pkg::cell_class_t expected_q[$];
        int mismatches;

        function new();
            robot_tall        = 12'd500;
            slope_span_max    = 11'd80;
            step_span_min     = 11'd120;
            step_span_max     = 11'd230;
            tall_obstacle_min = 12'd250;
            dense_occupancy   = 16'd128;
            slope_normal_min  = 16'd28377;
            wall_normal_max   = 16'd16384;
            mismatches        = 0;
        endfunction

        // Narrow registers keep only their low bits, as the hardware does.
        function void set_reg(tcc_pkg::reg_idx_t idx, logic [15:0] value);
            case (idx)
                tcc_pkg::REG_ROBOT_TALL:        robot_tall        = value[11:0];
                tcc_pkg::REG_SLOPE_SPAN_MAX:    slope_span_max    = value[10:0];
                tcc_pkg::REG_STEP_SPAN_MIN:     step_span_min     = value[10:0];
                tcc_pkg::REG_STEP_SPAN_MAX:     step_span_max     = value[10:0];
                tcc_pkg::REG_TALL_OBSTACLE_MIN: tall_obstacle_min = value[11:0];
                tcc_pkg::REG_DENSE_OCCUPANCY:   dense_occupancy   = value;
                tcc_pkg::REG_SLOPE_NORMAL_MIN:  slope_normal_min  = value;
                tcc_pkg::REG_WALL_NORMAL_MAX:   wall_normal_max   = value;
                default: ;
            endcase
        endfunction

        function tcc_pkg::cell_class_t classify(column_t c);
            int bottom;
            int top;
            int ground;
            int lo;
            int hi;
            int span;
            int occ_floor;
            logic blocks;
            logic slope_n;
            logic wall_n;
            logic mid_n;

            if (c.prior_mark == tcc_pkg::PRIOR_STEP)
                return tcc_pkg::CLASS_STEP;
            if (c.prior_mark == tcc_pkg::PRIOR_FREE)
                return tcc_pkg::CLASS_FREE;

            lo     = int'(c.column_low);
            hi     = int'(c.column_high);
            span   = int'(c.height_span);
            bottom = int'(c.robot_z) - int'(c.leg_offset);
            top    = bottom + int'(robot_tall);
            ground = bottom + int'(tcc_pkg::GroundToleranceMm);
            blocks = (lo < top) && (hi > ground);
            slope_n = c.normal_ok && (c.normal_up >= slope_normal_min);
            wall_n  = c.normal_ok && (c.normal_up < wall_normal_max);
            mid_n   = c.normal_ok && (c.normal_up >= wall_normal_max)
                      && (c.normal_up < slope_normal_min);

            if (c.point_total < 16'd2)
                return tcc_pkg::CLASS_FREE;
            if (lo > top)
                return tcc_pkg::CLASS_FREE;

            if (slope_n)
            begin
                if (lo <= ground + int'(slope_span_max))
                    return tcc_pkg::CLASS_FREE;
                if (lo <= ground + int'(step_span_max))
                    return tcc_pkg::CLASS_STEP;
                if (lo > top)
                    return tcc_pkg::CLASS_FREE;
            end

            if (c.occupancy > dense_occupancy && span > int'(slope_span_max))
            begin
                if (!(c.normal_ok && c.normal_up >= wall_normal_max) && blocks)
                    return tcc_pkg::CLASS_OBST;
            end

            if (wall_n && blocks)
                return tcc_pkg::CLASS_OBST;

            if (span < int'(slope_span_max))
                return tcc_pkg::CLASS_FREE;

            if (c.cliff_mark && c.lower_known)
                return tcc_pkg::CLASS_STEP;

            // Mid-range normal with sparse points reads as a gentle surface.
            occ_floor = (int'(dense_occupancy) * 4) / 5;
            if (mid_n)
            begin
                if (int'(c.occupancy) < occ_floor)
                    return tcc_pkg::CLASS_FREE;
            end

            return blocks ? tcc_pkg::CLASS_OBST : tcc_pkg::CLASS_FREE;
        endfunction

        function void note_column(column_t c);
            expected_q.insert(expected_q.size(), classify(c));
        endfunction

        function void check_class(logic [1:0] got);
            tcc_pkg::cell_class_t want;

            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cell_class: result %0d arrived with nothing expected", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cell_class mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] robot_z;
    logic [9:0]         leg_offset;
    logic signed [15:0] column_low;
    logic signed [15:0] column_high;
    logic [15:0]        height_span;
    logic [15:0]        point_total;
    logic [15:0]        occupancy;
    logic               normal_ok;
    logic [15:0]        normal_up;
    logic               cliff_mark;
    logic               lower_known;
    logic [1:0]         prior_mark;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         cell_class;

    scoreboard_t sb;
    bit idle_en;
    int cycles;

    terrain_column_classifier_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .robot_z     (robot_z),
        .leg_offset  (leg_offset),
        .column_low  (column_low),
        .column_high (column_high),
        .height_span (height_span),
        .point_total (point_total),
        .occupancy   (occupancy),
        .normal_ok   (normal_ok),
        .normal_up   (normal_up),
        .cliff_mark  (cliff_mark),
        .lower_known (lower_known),
        .prior_mark  (prior_mark),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_class  (cell_class)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_class(cell_class);
    end

    // The receiver takes results in runs and stalls in short bursts while idling is enabled.
    initial
    begin : result_sink
        int run;
        out_ready = 1'b1;
        forever
        begin
            run = $urandom_range(1, 16);
            out_ready = 1'b1;
            repeat (run) @(negedge clk);
            if (idle_en && $urandom_range(0, 1) == 1)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
        end
    end

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] usat16(int v);
        if (v > 65535)
            return 16'hFFFF;
        if (v < 0)
            return 16'h0000;
        return v[15:0];
    endfunction

    function automatic column_t make_column(int rz, int leg, int lo, int hi, int span, int pts,
                                            int occ, int nok, int nz, int cliff, int lower,
                                            int prior);
        column_t c;
        c.robot_z     = rz[15:0];
        c.leg_offset  = leg[9:0];
        c.column_low  = lo[15:0];
        c.column_high = hi[15:0];
        c.height_span = span[15:0];
        c.point_total = pts[15:0];
        c.occupancy   = occ[15:0];
        c.normal_ok   = nok[0];
        c.normal_up   = nz[15:0];
        c.cliff_mark  = cliff[0];
        c.lower_known = lower[0];
        c.prior_mark  = prior[1:0];
        return c;
    endfunction

    // Most columns are laid out around the robot and the current thresholds so that every rule
    // gets exercised; the rest is unconstrained noise.
    function automatic column_t random_column();
        column_t c;
        int bottom;
        int lo;
        int span;
        int thr;

        if ($urandom_range(0, 99) < 15)
        begin
            c.robot_z     = 16'($urandom);
            c.leg_offset  = 10'($urandom);
            c.column_low  = 16'($urandom);
            c.column_high = 16'($urandom);
            c.height_span = 16'($urandom);
            c.point_total = 16'($urandom);
            c.occupancy   = 16'($urandom);
            c.normal_ok   = 1'($urandom);
            c.normal_up   = 16'($urandom);
            c.cliff_mark  = 1'($urandom);
            c.lower_known = 1'($urandom);
            c.prior_mark  = 2'($urandom);
            return c;
        end

        c.robot_z    = sat16(int'($urandom_range(0, 8000)) - 4000);
        c.leg_offset = 10'($urandom_range(0, 1000));
        bottom = int'(c.robot_z) - int'(c.leg_offset);
        lo = bottom + int'($urandom_range(0, int'(sb.robot_tall) + 600)) - 300;

        case ($urandom_range(0, 4))
            0: thr = int'(sb.slope_span_max);
            1: thr = int'(sb.step_span_min);
            2: thr = int'(sb.step_span_max);
            3: thr = int'(sb.tall_obstacle_min);
            default: thr = -1;
        endcase
        if (thr < 0)
            span = $urandom_range(0, int'(sb.robot_tall) + 400);
        else
            span = thr + int'($urandom_range(0, 8)) - 4;
        if (span < 0)
            span = 0;

        c.column_low  = sat16(lo);
        c.height_span = usat16(span);
        if ($urandom_range(0, 9) == 0)
            c.column_high = sat16(lo + int'($urandom_range(0, 600)) - 300);
        else
            c.column_high = sat16(lo + span);

        if ($urandom_range(0, 9) == 0)
            c.point_total = 16'($urandom_range(0, 3));
        else
            c.point_total = 16'($urandom_range(2, 500));

        case ($urandom_range(0, 2))
            0: c.occupancy = usat16(int'(sb.dense_occupancy) + int'($urandom_range(0, 20)) - 10);
            1: c.occupancy = usat16((int'(sb.dense_occupancy) * 4) / 5
                                    + int'($urandom_range(0, 6)) - 3);
            default: c.occupancy = 16'($urandom_range(0, 1024));
        endcase

        c.normal_ok = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 2))
            0: c.normal_up = usat16(int'(sb.slope_normal_min) + int'($urandom_range(0, 6)) - 3);
            1: c.normal_up = usat16(int'(sb.wall_normal_max) + int'($urandom_range(0, 6)) - 3);
            default: c.normal_up = 16'($urandom_range(0, 32768));
        endcase

        c.cliff_mark  = 1'($urandom);
        c.lower_known = 1'($urandom);
        if ($urandom_range(0, 4) == 0)
            c.prior_mark = 2'($urandom);
        else
            c.prior_mark = tcc_pkg::PRIOR_UNKNOWN;
        return c;
    endfunction

    task automatic write_reg(tcc_pkg::reg_idx_t idx, int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[15:0];
        sb.set_reg(idx, value[15:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic program_thresholds(int tall, int slope_span, int step_min, int step_max,
                                      int tall_min, int dense, int slope_n, int wall_n);
        write_reg(tcc_pkg::REG_ROBOT_TALL, tall);
        write_reg(tcc_pkg::REG_SLOPE_SPAN_MAX, slope_span);
        write_reg(tcc_pkg::REG_STEP_SPAN_MIN, step_min);
        write_reg(tcc_pkg::REG_STEP_SPAN_MAX, step_max);
        write_reg(tcc_pkg::REG_TALL_OBSTACLE_MIN, tall_min);
        write_reg(tcc_pkg::REG_DENSE_OCCUPANCY, dense);
        write_reg(tcc_pkg::REG_SLOPE_NORMAL_MIN, slope_n);
        write_reg(tcc_pkg::REG_WALL_NORMAL_MAX, wall_n);
    endtask

    task automatic apply_setting(int k);
        int a;
        int b;
        int s;
        case (k)
            0: program_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
            1: program_thresholds(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
            2: program_thresholds(4000, 2000, 2000, 2000, 4000, 65535, 32768, 32768);
            6: program_thresholds($urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom);
            7: program_thresholds(500, 80, 120, 230, 250, 128, 28377, 16384);
            default:
            begin
                a = $urandom_range(0, 600);
                b = a + int'($urandom_range(0, 400));
                s = $urandom_range(16384, 32768);
                program_thresholds($urandom_range(0, 4000), $urandom_range(0, 400), a, b,
                                   b + int'($urandom_range(0, 300)), $urandom_range(0, 512),
                                   s, $urandom_range(0, s));
            end
        endcase
    endtask

    // Called just after a falling edge; returns just after the falling edge after the transfer.
    task automatic send_column(column_t c);
        int gap;
        gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        robot_z     = c.robot_z;
        leg_offset  = c.leg_offset;
        column_low  = c.column_low;
        column_high = c.column_high;
        height_span = c.height_span;
        point_total = c.point_total;
        occupancy   = c.occupancy;
        normal_ok   = c.normal_ok;
        normal_up   = c.normal_up;
        cliff_mark  = c.cliff_mark;
        lower_known = c.lower_known;
        prior_mark  = c.prior_mark;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_column(c);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    initial
    begin : stimulus
        sb = new();
        idle_en     = 1'b1;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = tcc_pkg::REG_ROBOT_TALL;
        cfg_data    = '0;
        in_valid    = 1'b0;
        robot_z     = '0;
        leg_offset  = '0;
        column_low  = '0;
        column_high = '0;
        height_span = '0;
        point_total = '0;
        occupancy   = '0;
        normal_ok   = 1'b0;
        normal_up   = '0;
        cliff_mark  = 1'b0;
        lower_known = 1'b0;
        prior_mark  = tcc_pkg::PRIOR_UNKNOWN;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset thresholds; robot bottom at 0 mm, so top is 500 mm and ground 80 mm.
        send_column(make_column(300, 300, 0, 300, 300, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_STEP));
        send_column(make_column(300, 300, 0, 300, 300, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_FREE));
        send_column(make_column(300, 300, 0, 300, 300, 100, 0, 0, 0, 0, 0, 3));
        send_column(make_column(300, 300, 0, 300, 300, 0, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 300, 300, 1, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 600, 900, 300, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 100, 150, 50, 100, 0, 1, 30000, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 250, 300, 50, 100, 0, 1, 30000, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 150, 150, 100, 200, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 100, 100, 100, 0, 1, 1000, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 50, 50, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 100, 100, 100, 0, 0, 0, 1, 1,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 150, 150, 100, 50, 1, 20000, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 150, 150, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, -300, -150, 150, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 300, 300, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, -400, -160, 240, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 100, 100, 100, 0, 0, 0, 1, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        // Span that disagrees with the low and high heights.
        send_column(make_column(300, 300, 0, 300, 10, 100, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        // Normal z above one, and exactly one.
        send_column(make_column(300, 300, 0, 100, 100, 100, 0, 1, 65535, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(300, 300, 0, 100, 100, 100, 0, 1, 32768, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(32767, 1023, 32767, 32767, 65535, 65535, 65535, 1, 65535,
                                1, 1, tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(-32768, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));
        send_column(make_column(-32768, 1023, -32768, 32767, 65535, 2, 0, 0, 0, 0, 0,
                                tcc_pkg::PRIOR_UNKNOWN));

        for (int k = 0; k < SettingCount; k++)
        begin
            wait_drained();
            apply_setting(k);
            for (int i = 0; i < ItemsPerSetting; i++)
            begin
                idle_en = (k < SettingCount - 1) && (i < (ItemsPerSetting * 2) / 3);
                send_column(random_column());
            end
        end

        in_valid = 1'b0;
        idle_en  = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
